>>> sv/torque_vectoring_linear_bias_top_macros.svh
// assertion macros for the torque vectoring linear bias block
// used by the port checker; expects i_clk and i_rst_n in scope
`ifndef TORQUE_VECTORING_LINEAR_BIAS_TOP_MACROS_SVH
`define TORQUE_VECTORING_LINEAR_BIAS_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define TVLB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TVLB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/tvlb_pkg.sv
// shared types, widths and constants of the torque vectoring linear bias block
// no dependencies
`default_nettype none

package tvlb_pkg;

    // field widths
    localparam int BIAS_W     = 16;
    localparam int ANG_W      = 15;
    localparam int TRQ_W      = 16;
    localparam int X_W        = 16;
    localparam int DY_W       = 15;
    localparam int PROD_W     = 31;
    localparam int NUM_W      = 29;
    localparam int Q_W        = 14;
    localparam int DIV_STAGES = Q_W;
    localparam int PA_W       = 33;
    localparam int PW         = 47;
    localparam int FRAC_SH    = 30;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DRV_REAR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RGN_REAR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_BEGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_END  = 3'd4;

    // q1.15 constants
    localparam logic [BIAS_W-1:0] ONE_Q15  = 16'h8000;
    localparam logic [BIAS_W-1:0] HALF_Q15 = 16'h4000;

    // register reset values
    localparam logic [BIAS_W-1:0] DRV_REAR_RST  = 16'd16384;
    localparam logic [BIAS_W-1:0] RGN_REAR_RST  = 16'd16384;
    localparam logic [ANG_W-1:0]  ANG_BEGIN_RST = 15'd0;
    localparam logic [ANG_W-1:0]  ANG_END_RST   = 15'd9000;
    localparam logic [BIAS_W-1:0] LEFT_END_RST  = 16'd16384;

    // where the absolute angle falls on the interpolation axis
    typedef enum logic [1:0] {
        RGN_BEGIN = 2'd0,
        RGN_END   = 2'd1,
        RGN_MID   = 2'd2
    } t_region;

    // decoded configuration; the user must keep it stable while words are in flight, the block does not enforce it
    typedef struct packed {
        logic [BIAS_W-1:0] drv_rear;
        logic [BIAS_W-1:0] rgn_rear;
        logic [ANG_W-1:0]  x1;
        logic [ANG_W-1:0]  x2;
        logic              asc;
        logic [ANG_W-1:0]  den;
        logic [BIAS_W-1:0] endb_pos;
        logic [BIAS_W-1:0] endb_neg;
    } t_cfg;

    // per-word sideband carried down the pipeline
    typedef struct packed {
        logic                    sv;
        logic signed [TRQ_W-1:0] req;
        logic [BIAS_W-1:0]       rear;
        logic [BIAS_W-1:0]       front;
        t_region                 region;
        logic [BIAS_W-1:0]       y2;
        logic                    dneg;
    } t_item;

    // clamp a bias register to one
    function automatic logic [BIAS_W-1:0] sat_bias(input logic [BIAS_W-1:0] b);
        return (b > ONE_Q15) ? ONE_Q15 : b;
    endfunction

endpackage

`default_nettype wire

>>> sv/tvlb_cfg.sv
// configuration registers and decoded bias/axis values
// depends on tvlb_pkg
`default_nettype none

module tvlb_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tvlb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tvlb_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output tvlb_pkg::t_cfg                       o_cfg
);

    logic [tvlb_pkg::BIAS_W-1:0] r_drv_rear;
    logic [tvlb_pkg::BIAS_W-1:0] r_rgn_rear;
    logic [tvlb_pkg::ANG_W-1:0]  r_ang_begin;
    logic [tvlb_pkg::ANG_W-1:0]  r_ang_end;
    logic [tvlb_pkg::BIAS_W-1:0] r_left_end;
    logic [tvlb_pkg::BIAS_W-1:0] w_endb;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drv_rear  <= tvlb_pkg::DRV_REAR_RST;
            r_rgn_rear  <= tvlb_pkg::RGN_REAR_RST;
            r_ang_begin <= tvlb_pkg::ANG_BEGIN_RST;
            r_ang_end   <= tvlb_pkg::ANG_END_RST;
            r_left_end  <= tvlb_pkg::LEFT_END_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tvlb_pkg::CFG_DRV_REAR:  r_drv_rear  <= i_cfg_wdata;
                tvlb_pkg::CFG_RGN_REAR:  r_rgn_rear  <= i_cfg_wdata;
                tvlb_pkg::CFG_ANG_BEGIN: r_ang_begin <= i_cfg_wdata[tvlb_pkg::ANG_W-1:0];
                tvlb_pkg::CFG_ANG_END:   r_ang_end   <= i_cfg_wdata[tvlb_pkg::ANG_W-1:0];
                tvlb_pkg::CFG_LEFT_END:  r_left_end  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // saturated biases, axis direction and span
    always_comb begin
        w_endb         = tvlb_pkg::sat_bias(r_left_end);
        o_cfg.drv_rear = tvlb_pkg::sat_bias(r_drv_rear);
        o_cfg.rgn_rear = tvlb_pkg::sat_bias(r_rgn_rear);
        o_cfg.x1       = r_ang_begin;
        o_cfg.x2       = r_ang_end;
        o_cfg.asc      = (r_ang_begin <= r_ang_end);
        o_cfg.den      = o_cfg.asc ? (r_ang_end - r_ang_begin) : (r_ang_begin - r_ang_end);
        o_cfg.endb_pos = w_endb;
        o_cfg.endb_neg = tvlb_pkg::ONE_Q15 - w_endb;
    end

endmodule

`default_nettype wire

>>> sv/tvlb_front.sv
// front stages: input register, axis region and deltas, interpolation numerator
// depends on tvlb_pkg
`default_nettype none

module tvlb_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire tvlb_pkg::t_cfg                     i_cfg,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic signed [tvlb_pkg::TRQ_W-1:0]  i_torque_request,
    input  wire logic signed [tvlb_pkg::TRQ_W-1:0]  i_steering_angle,
    input  wire logic                               i_sensor_valid,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output tvlb_pkg::t_item                         o_item,
    output logic [tvlb_pkg::NUM_W-1:0]              o_num
);

    // stage 1: raw input word
    logic                              r_v1;
    logic signed [tvlb_pkg::TRQ_W-1:0] r_req1;
    logic signed [tvlb_pkg::TRQ_W-1:0] r_ang1;
    logic                              r_sv1;
    // stage 2: sideband and deltas
    logic                              r_v2;
    tvlb_pkg::t_item                   r_it2;
    logic [tvlb_pkg::X_W-1:0]          r_dx2;
    logic [tvlb_pkg::DY_W-1:0]         r_dy2;
    // stage 3: numerator
    logic                              r_v3;
    tvlb_pkg::t_item                   r_it3;
    logic [tvlb_pkg::NUM_W-1:0]        r_num3;

    logic w_hold1, w_hold2, w_hold3;

    tvlb_pkg::t_item             n_it2;
    logic [tvlb_pkg::X_W-1:0]    n_dx2;
    logic [tvlb_pkg::DY_W-1:0]   n_dy2;
    logic                        w_drv;
    logic [tvlb_pkg::X_W-1:0]    w_x;
    logic [tvlb_pkg::X_W-1:0]    w_x1;
    logic [tvlb_pkg::X_W-1:0]    w_x2;
    logic                        w_at_begin;
    logic                        w_at_end;
    logic [tvlb_pkg::PROD_W-1:0] w_prod;

    // stall chain, a stage holds only when full and blocked downstream
    assign w_hold3 = r_v3 && i_stall;
    assign w_hold2 = r_v2 && w_hold3;
    assign w_hold1 = r_v1 && w_hold2;
    assign o_stall = w_hold1;

    // region and deltas from the absolute angle
    always_comb begin
        w_drv = !r_req1[tvlb_pkg::TRQ_W-1];
        w_x   = r_ang1[tvlb_pkg::TRQ_W-1] ? tvlb_pkg::X_W'(-r_ang1) : tvlb_pkg::X_W'(r_ang1);
        w_x1  = {1'b0, i_cfg.x1};
        w_x2  = {1'b0, i_cfg.x2};

        if (i_cfg.asc) begin
            w_at_begin = (w_x <= w_x1);
            w_at_end   = (w_x >= w_x2);
            n_dx2      = w_x - w_x1;
        end else begin
            w_at_begin = (w_x >= w_x1);
            w_at_end   = (w_x <= w_x2);
            n_dx2      = w_x1 - w_x;
        end

        n_it2.sv    = r_sv1;
        n_it2.req   = r_req1;
        n_it2.rear  = w_drv ? i_cfg.drv_rear : i_cfg.rgn_rear;
        n_it2.front = tvlb_pkg::ONE_Q15 - n_it2.rear;
        n_it2.y2    = r_ang1[tvlb_pkg::TRQ_W-1] ? i_cfg.endb_neg : i_cfg.endb_pos;
        n_it2.dneg  = (n_it2.y2 < tvlb_pkg::HALF_Q15);

        // regen and the begin side both give one half
        if (!w_drv || w_at_begin) begin
            n_it2.region = tvlb_pkg::RGN_BEGIN;
        end else if (w_at_end) begin
            n_it2.region = tvlb_pkg::RGN_END;
        end else begin
            n_it2.region = tvlb_pkg::RGN_MID;
        end

        n_dy2 = n_it2.dneg ? tvlb_pkg::DY_W'(tvlb_pkg::HALF_Q15 - n_it2.y2)
                           : tvlb_pkg::DY_W'(n_it2.y2 - tvlb_pkg::HALF_Q15);
    end

    // numerator |dy| * |dx|, below 2^29 inside the interpolation span
    assign w_prod = tvlb_pkg::PROD_W'(r_dy2) * tvlb_pkg::PROD_W'(r_dx2);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (!w_hold1) r_v1 <= i_valid;
            if (!w_hold2) r_v2 <= r_v1;
            if (!w_hold3) r_v3 <= r_v2;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (!w_hold1) begin
            r_req1 <= i_torque_request;
            r_ang1 <= i_steering_angle;
            r_sv1  <= i_sensor_valid;
        end
        if (!w_hold2) begin
            r_it2 <= n_it2;
            r_dx2 <= n_dx2;
            r_dy2 <= n_dy2;
        end
        if (!w_hold3) begin
            r_it3  <= r_it2;
            r_num3 <= w_prod[tvlb_pkg::NUM_W-1:0];
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_it3;
    assign o_num   = r_num3;

endmodule

`default_nettype wire

>>> sv/tvlb_div.sv
// pipelined restoring divider, one quotient bit per stage, sideband carried along
// depends on tvlb_pkg
`default_nettype none

module tvlb_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [tvlb_pkg::ANG_W-1:0]  i_den,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire tvlb_pkg::t_item             i_item,
    input  wire logic [tvlb_pkg::NUM_W-1:0]  i_num,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output tvlb_pkg::t_item                  o_item,
    output logic [tvlb_pkg::Q_W-1:0]         o_q
);

    logic                       r_v   [tvlb_pkg::DIV_STAGES];
    tvlb_pkg::t_item            r_it  [tvlb_pkg::DIV_STAGES];
    logic [tvlb_pkg::NUM_W-1:0] r_rem [tvlb_pkg::DIV_STAGES];
    logic [tvlb_pkg::Q_W-1:0]   r_q   [tvlb_pkg::DIV_STAGES];

    logic                       w_hold [tvlb_pkg::DIV_STAGES];
    logic                       w_vin  [tvlb_pkg::DIV_STAGES];
    tvlb_pkg::t_item            w_itin [tvlb_pkg::DIV_STAGES];
    logic [tvlb_pkg::NUM_W-1:0] w_rin  [tvlb_pkg::DIV_STAGES];
    logic [tvlb_pkg::Q_W-1:0]   w_qin  [tvlb_pkg::DIV_STAGES];
    logic [tvlb_pkg::NUM_W-1:0] w_dsh  [tvlb_pkg::DIV_STAGES];
    logic                       w_ge   [tvlb_pkg::DIV_STAGES];

    for (genvar s = 0; s < tvlb_pkg::DIV_STAGES; s++) begin : g_stg
        localparam int B = tvlb_pkg::Q_W - 1 - s;

        // stage input
        if (s == 0) begin : g_first
            assign w_vin[s]  = i_valid;
            assign w_itin[s] = i_item;
            assign w_rin[s]  = i_num;
            assign w_qin[s]  = '0;
        end else begin : g_next
            assign w_vin[s]  = r_v[s-1];
            assign w_itin[s] = r_it[s-1];
            assign w_rin[s]  = r_rem[s-1];
            assign w_qin[s]  = r_q[s-1];
        end

        // stall chain
        if (s == tvlb_pkg::DIV_STAGES - 1) begin : g_last_hold
            assign w_hold[s] = r_v[s] && i_stall;
        end else begin : g_mid_hold
            assign w_hold[s] = r_v[s] && w_hold[s+1];
        end

        // trial subtract of the shifted divisor
        assign w_dsh[s] = tvlb_pkg::NUM_W'(i_den) << B;
        assign w_ge[s]  = (w_rin[s] >= w_dsh[s]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (!w_hold[s]) begin
                r_v[s] <= w_vin[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!w_hold[s]) begin
                r_it[s]  <= w_itin[s];
                r_rem[s] <= w_ge[s] ? (w_rin[s] - w_dsh[s]) : w_rin[s];
                r_q[s]   <= w_qin[s] | (w_ge[s] ? (tvlb_pkg::Q_W'(1) << B) : '0);
            end
        end
    end

    assign o_stall = w_hold[0];
    assign o_valid = r_v[tvlb_pkg::DIV_STAGES-1];
    assign o_item  = r_it[tvlb_pkg::DIV_STAGES-1];
    assign o_q     = r_q[tvlb_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

>>> sv/tvlb_mix.sv
// back stages: left/right shares, axle and wheel products, scaling and output register
// depends on tvlb_pkg
`default_nettype none

module tvlb_mix (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire tvlb_pkg::t_item                    i_item,
    input  wire logic [tvlb_pkg::Q_W-1:0]           i_q,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic                                    o_out_valid,
    output logic signed [tvlb_pkg::TRQ_W-1:0]       o_torque_rear_left,
    output logic signed [tvlb_pkg::TRQ_W-1:0]       o_torque_rear_right,
    output logic signed [tvlb_pkg::TRQ_W-1:0]       o_torque_front_left,
    output logic signed [tvlb_pkg::TRQ_W-1:0]       o_torque_front_right
);

    // stage 1: side shares and request times axle share
    logic                             r_v1;
    logic                             r_sv1;
    logic [tvlb_pkg::BIAS_W-1:0]      r_left1;
    logic [tvlb_pkg::BIAS_W-1:0]      r_right1;
    logic signed [tvlb_pkg::PA_W-1:0] r_pa1;
    logic signed [tvlb_pkg::PA_W-1:0] r_pb1;
    // stage 2: full wheel products
    logic                             r_v2;
    logic                             r_sv2;
    logic signed [tvlb_pkg::PW-1:0]   r_prl2;
    logic signed [tvlb_pkg::PW-1:0]   r_prr2;
    logic signed [tvlb_pkg::PW-1:0]   r_pfl2;
    logic signed [tvlb_pkg::PW-1:0]   r_pfr2;
    // stage 3: output register
    logic                             r_v3;
    logic                             r_sv3;
    logic signed [tvlb_pkg::TRQ_W-1:0] r_rl3;
    logic signed [tvlb_pkg::TRQ_W-1:0] r_rr3;
    logic signed [tvlb_pkg::TRQ_W-1:0] r_fl3;
    logic signed [tvlb_pkg::TRQ_W-1:0] r_fr3;

    logic w_hold1, w_hold2, w_hold3;

    logic [tvlb_pkg::BIAS_W-1:0]      n_left1;
    logic [tvlb_pkg::BIAS_W-1:0]      w_qx;
    logic signed [tvlb_pkg::PA_W-1:0] n_pa1;
    logic signed [tvlb_pkg::PA_W-1:0] n_pb1;
    logic signed [tvlb_pkg::PW-1:0]   w_left_s;
    logic signed [tvlb_pkg::PW-1:0]   w_right_s;

    // divide by 2^30 toward zero, then clamp to 16 bit signed
    function automatic logic signed [tvlb_pkg::TRQ_W-1:0] wheel_scale(
        input logic signed [tvlb_pkg::PW-1:0] p
    );
        logic signed [tvlb_pkg::PW-tvlb_pkg::FRAC_SH-1:0] q;
        logic                                             rnd;
        q   = p[tvlb_pkg::PW-1:tvlb_pkg::FRAC_SH];
        rnd = p[tvlb_pkg::PW-1] && (p[tvlb_pkg::FRAC_SH-1:0] != '0);
        q   = q + $signed({{(tvlb_pkg::PW-tvlb_pkg::FRAC_SH-1){1'b0}}, rnd});
        if (q > 17'sd32767) begin
            return 16'sh7fff;
        end else if (q < -17'sd32768) begin
            return 16'sh8000;
        end
        return q[tvlb_pkg::TRQ_W-1:0];
    endfunction

    assign w_hold3 = r_v3 && i_stall;
    assign w_hold2 = r_v2 && w_hold3;
    assign w_hold1 = r_v1 && w_hold2;
    assign o_stall = w_hold1;

    // left share from region and quotient
    always_comb begin
        w_qx = tvlb_pkg::BIAS_W'(i_q);
        unique case (i_item.region)
            tvlb_pkg::RGN_BEGIN: n_left1 = tvlb_pkg::HALF_Q15;
            tvlb_pkg::RGN_END:   n_left1 = i_item.y2;
            tvlb_pkg::RGN_MID:   n_left1 = i_item.dneg ? (tvlb_pkg::HALF_Q15 - w_qx)
                                                       : (tvlb_pkg::HALF_Q15 + w_qx);
            default:             n_left1 = tvlb_pkg::HALF_Q15;
        endcase
    end

    // request times rear and front share
    assign n_pa1 = tvlb_pkg::PA_W'(i_item.req)
                 * tvlb_pkg::PA_W'($signed({1'b0, i_item.rear}));
    assign n_pb1 = tvlb_pkg::PA_W'(i_item.req)
                 * tvlb_pkg::PA_W'($signed({1'b0, i_item.front}));

    assign w_left_s  = tvlb_pkg::PW'($signed({1'b0, r_left1}));
    assign w_right_s = tvlb_pkg::PW'($signed({1'b0, r_right1}));

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (!w_hold1) r_v1 <= i_valid;
            if (!w_hold2) r_v2 <= r_v1;
            if (!w_hold3) r_v3 <= r_v2;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (!w_hold1) begin
            r_sv1    <= i_item.sv;
            r_left1  <= n_left1;
            r_right1 <= tvlb_pkg::ONE_Q15 - n_left1;
            r_pa1    <= n_pa1;
            r_pb1    <= n_pb1;
        end
        if (!w_hold2) begin
            r_sv2  <= r_sv1;
            r_prl2 <= tvlb_pkg::PW'(r_pa1) * w_left_s;
            r_prr2 <= tvlb_pkg::PW'(r_pa1) * w_right_s;
            r_pfl2 <= tvlb_pkg::PW'(r_pb1) * w_left_s;
            r_pfr2 <= tvlb_pkg::PW'(r_pb1) * w_right_s;
        end
        if (!w_hold3) begin
            r_sv3 <= r_sv2;
            r_rl3 <= wheel_scale(r_prl2);
            r_rr3 <= wheel_scale(r_prr2);
            r_fl3 <= wheel_scale(r_pfl2);
            r_fr3 <= wheel_scale(r_pfr2);
        end
    end

    assign o_valid              = r_v3;
    assign o_out_valid          = r_sv3;
    assign o_torque_rear_left   = r_rl3;
    assign o_torque_rear_right  = r_rr3;
    assign o_torque_front_left  = r_fl3;
    assign o_torque_front_right = r_fr3;

endmodule

`default_nettype wire

>>> sv/torque_vectoring_linear_bias_top.sv
// throughput: one word per cycle while i_stall is low; set by the 20-stage pipeline, 14 of its stages
// being the one-bit-per-stage divider of the steering interpolation
// empty stages are filled while later ones stall, so no bubble blocks the input
// reset (sync, active low) clears every stage valid bit and loads the register defaults
`default_nettype none

module torque_vectoring_linear_bias_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [tvlb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tvlb_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // input channel
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic signed [tvlb_pkg::TRQ_W-1:0]  i_torque_request,
    input  wire logic signed [tvlb_pkg::TRQ_W-1:0]  i_steering_angle,
    input  wire logic                               i_sensor_valid,
    // output channel
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic                                    o_out_valid,
    output logic signed [tvlb_pkg::TRQ_W-1:0]       o_torque_rear_left,
    output logic signed [tvlb_pkg::TRQ_W-1:0]       o_torque_rear_right,
    output logic signed [tvlb_pkg::TRQ_W-1:0]       o_torque_front_left,
    output logic signed [tvlb_pkg::TRQ_W-1:0]       o_torque_front_right
);

    tvlb_pkg::t_cfg             w_cfg;
    logic                       w_fd_valid;
    logic                       w_fd_stall;
    tvlb_pkg::t_item            w_fd_item;
    logic [tvlb_pkg::NUM_W-1:0] w_fd_num;
    logic                       w_dm_valid;
    logic                       w_dm_stall;
    tvlb_pkg::t_item            w_dm_item;
    logic [tvlb_pkg::Q_W-1:0]   w_dm_q;

    // configuration registers
    tvlb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // input register, region decode, numerator
    tvlb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_torque_request (i_torque_request),
        .i_steering_angle (i_steering_angle),
        .i_sensor_valid   (i_sensor_valid),
        .o_valid          (w_fd_valid),
        .i_stall          (w_fd_stall),
        .o_item           (w_fd_item),
        .o_num            (w_fd_num)
    );

    // interpolation divide
    tvlb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_den   (w_cfg.den),
        .i_valid (w_fd_valid),
        .o_stall (w_fd_stall),
        .i_item  (w_fd_item),
        .i_num   (w_fd_num),
        .o_valid (w_dm_valid),
        .i_stall (w_dm_stall),
        .o_item  (w_dm_item),
        .o_q     (w_dm_q)
    );

    // wheel torque products and output register
    tvlb_mix u_mix (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (w_dm_valid),
        .o_stall              (w_dm_stall),
        .i_item               (w_dm_item),
        .i_q                  (w_dm_q),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_out_valid          (o_out_valid),
        .o_torque_rear_left   (o_torque_rear_left),
        .o_torque_rear_right  (o_torque_rear_right),
        .o_torque_front_left  (o_torque_front_left),
        .o_torque_front_right (o_torque_front_right)
    );

endmodule

`default_nettype wire

>>> sv/tvlb_chk.sv
// port-level checker for the torque vectoring linear bias top, bound below
// depends on tvlb_pkg and torque_vectoring_linear_bias_top_macros.svh
`default_nettype none

`include "torque_vectoring_linear_bias_top_macros.svh"

module tvlb_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_stall,
    input wire logic                              o_valid,
    input wire logic                              i_stall,
    input wire logic                              o_out_valid,
    input wire logic signed [tvlb_pkg::TRQ_W-1:0] o_torque_rear_left,
    input wire logic signed [tvlb_pkg::TRQ_W-1:0] o_torque_rear_right,
    input wire logic signed [tvlb_pkg::TRQ_W-1:0] o_torque_front_left,
    input wire logic signed [tvlb_pkg::TRQ_W-1:0] o_torque_front_right
);

    logic                      w_any_neg;
    logic                      w_any_pos;
    logic                      w_even;
    logic                      w_held;
    logic [4*tvlb_pkg::TRQ_W:0] w_out_word;

    // every share is non-negative, so no wheel opposes the request
    assign w_any_neg = o_torque_rear_left[tvlb_pkg::TRQ_W-1]
                    || o_torque_rear_right[tvlb_pkg::TRQ_W-1]
                    || o_torque_front_left[tvlb_pkg::TRQ_W-1]
                    || o_torque_front_right[tvlb_pkg::TRQ_W-1];
    assign w_any_pos = (o_torque_rear_left > 16'sd0) || (o_torque_rear_right > 16'sd0)
                    || (o_torque_front_left > 16'sd0) || (o_torque_front_right > 16'sd0);

    // left and right equal on both axles
    assign w_even = (o_torque_rear_left == o_torque_rear_right)
                 && (o_torque_front_left == o_torque_front_right);

    // output word waiting under stall
    assign w_held     = o_valid && i_stall;
    assign w_out_word = {o_out_valid, o_torque_rear_left, o_torque_rear_right,
                         o_torque_front_left, o_torque_front_right};

    `TVLB_ASSERT_NEXT(a_out_hold, w_held, o_valid && $stable(w_out_word), "output moved under stall")
    `TVLB_ASSERT_NOW(a_sign_agree, o_valid, !(w_any_neg && w_any_pos), "mixed torque signs")
    `TVLB_ASSERT_NOW(a_regen_split, o_valid && w_any_neg, w_even, "regen not split evenly")
    `TVLB_ASSERT_NOW(a_no_false_stall, !o_valid, !o_stall, "stall with empty output")

endmodule

bind torque_vectoring_linear_bias_top tvlb_chk u_tvlb_chk (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_stall              (o_stall),
    .o_valid              (o_valid),
    .i_stall              (i_stall),
    .o_out_valid          (o_out_valid),
    .o_torque_rear_left   (o_torque_rear_left),
    .o_torque_rear_right  (o_torque_rear_right),
    .o_torque_front_left  (o_torque_front_left),
    .o_torque_front_right (o_torque_front_right)
);

`default_nettype wire

>>> test/tb_torque_vectoring_linear_bias_top.sv
`timescale 1ns / 1ps
// testbench for torque_vectoring_linear_bias_top: directed and random words whose
// four wheel torques are predicted in the bench and compared as they come out
// depends on tvlb_pkg and the block's rtl
module tb_torque_vectoring_linear_bias_top;

    localparam int DRAIN_CYCLES = 25;
    localparam int MAX_REPORTS  = 10;

    // one expected output word
    typedef struct packed {
        logic                              sv;
        logic signed [tvlb_pkg::TRQ_W-1:0] rl;
        logic signed [tvlb_pkg::TRQ_W-1:0] rr;
        logic signed [tvlb_pkg::TRQ_W-1:0] fl;
        logic signed [tvlb_pkg::TRQ_W-1:0] fr;
    } t_split;

    logic                              i_clk            = 1'b0;
    logic                              i_rst_n          = 1'b0;
    logic                              i_cfg_we         = 1'b0;
    logic [tvlb_pkg::CFG_IDX_W-1:0]    i_cfg_idx        = tvlb_pkg::CFG_DRV_REAR;
    logic [tvlb_pkg::CFG_DATA_W-1:0]   i_cfg_wdata      = '0;
    logic                              i_valid          = 1'b0;
    logic                              o_stall;
    logic signed [tvlb_pkg::TRQ_W-1:0] i_torque_request = '0;
    logic signed [tvlb_pkg::TRQ_W-1:0] i_steering_angle = '0;
    logic                              i_sensor_valid   = 1'b0;
    logic                              o_valid;
    logic                              i_stall          = 1'b0;
    logic                              o_out_valid;
    logic signed [tvlb_pkg::TRQ_W-1:0] o_torque_rear_left;
    logic signed [tvlb_pkg::TRQ_W-1:0] o_torque_rear_right;
    logic signed [tvlb_pkg::TRQ_W-1:0] o_torque_front_left;
    logic signed [tvlb_pkg::TRQ_W-1:0] o_torque_front_right;

    // bench copy of the configuration registers
    logic [tvlb_pkg::BIAS_W-1:0] cfg_drv_rear  = tvlb_pkg::DRV_REAR_RST;
    logic [tvlb_pkg::BIAS_W-1:0] cfg_rgn_rear  = tvlb_pkg::RGN_REAR_RST;
    logic [tvlb_pkg::ANG_W-1:0]  cfg_ang_begin = tvlb_pkg::ANG_BEGIN_RST;
    logic [tvlb_pkg::ANG_W-1:0]  cfg_ang_end   = tvlb_pkg::ANG_END_RST;
    logic [tvlb_pkg::BIAS_W-1:0] cfg_left_end  = tvlb_pkg::LEFT_END_RST;

    t_split      pending_splits[$];
    int          n_mismatch    = 0;
    int unsigned snd_idle_pct  = 0;
    int unsigned rcv_stall_pct = 0;

    torque_vectoring_linear_bias_top dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_torque_request     (i_torque_request),
        .i_steering_angle     (i_steering_angle),
        .i_sensor_valid       (i_sensor_valid),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_out_valid          (o_out_valid),
        .o_torque_rear_left   (o_torque_rear_left),
        .o_torque_rear_right  (o_torque_rear_right),
        .o_torque_front_left  (o_torque_front_left),
        .o_torque_front_right (o_torque_front_right)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // q1.15 fraction clamped to one
    function automatic longint clamp_unity(input longint b);
        return (b > 32768) ? 64'sd32768 : b;
    endfunction

    // request * axle * side / 2^30, truncated toward zero, then saturated
    function automatic logic signed [tvlb_pkg::TRQ_W-1:0] wheel_torque(input longint req,
                                                                       input longint axle,
                                                                       input longint side);
        longint p;
        p = (req * axle * side) / (64'sd1 <<< tvlb_pkg::FRAC_SH);
        if (p > 32767)
            p = 32767;
        else if (p < -32768)
            p = -32768;
        return p[tvlb_pkg::TRQ_W-1:0];
    endfunction

    // expected wheel split for one input word under the current registers
    function automatic t_split predict_split(input logic signed [tvlb_pkg::TRQ_W-1:0] trq,
                                             input logic signed [tvlb_pkg::TRQ_W-1:0] ang,
                                             input logic sv);
        longint req, x, x1, x2, y2, rear, front, left, right;
        t_split s;
        req   = trq;
        x     = (ang < 0) ? -longint'(ang) : longint'(ang);
        rear  = clamp_unity((req >= 0) ? cfg_drv_rear : cfg_rgn_rear);
        front = 32768 - rear;
        left  = 16384;
        // driving: interpolate left share over the absolute angle
        if (req >= 0) begin
            y2 = clamp_unity(cfg_left_end);
            if (ang < 0)
                y2 = 32768 - y2;
            x1 = cfg_ang_begin;
            x2 = cfg_ang_end;
            if ((x1 <= x2) ? (x <= x1) : (x >= x1))
                left = 16384;
            else if ((x1 <= x2) ? (x >= x2) : (x <= x2))
                left = y2;
            else
                left = 16384 + ((y2 - 16384) * (x - x1)) / (x2 - x1);
        end
        right = 32768 - left;
        s.sv  = sv;
        s.rl  = wheel_torque(req, rear, left);
        s.rr  = wheel_torque(req, rear, right);
        s.fl  = wheel_torque(req, front, left);
        s.fr  = wheel_torque(req, front, right);
        return s;
    endfunction

    task automatic flag_error(input string msg);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [tvlb_pkg::TRQ_W-1:0] want,
                               input logic [tvlb_pkg::TRQ_W-1:0] got);
        if (got !== want)
            flag_error($sformatf("%s mismatch: expected %0d, got %0d",
                                 name, $signed(want), $signed(got)));
    endtask

    // random receiver stall
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    // compare each accepted output word against the oldest prediction
    always @(posedge i_clk) begin
        t_split want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_splits.size() == 0) begin
                flag_error($sformatf("unexpected word: sv %0b rl %0d rr %0d fl %0d fr %0d",
                                     o_out_valid, o_torque_rear_left, o_torque_rear_right,
                                     o_torque_front_left, o_torque_front_right));
            end else begin
                want = pending_splits.pop_front();
                check_field("out_valid", {{(tvlb_pkg::TRQ_W-1){1'b0}}, want.sv},
                            {{(tvlb_pkg::TRQ_W-1){1'b0}}, o_out_valid});
                check_field("torque_rear_left", want.rl, o_torque_rear_left);
                check_field("torque_rear_right", want.rr, o_torque_rear_right);
                check_field("torque_front_left", want.fl, o_torque_front_left);
                check_field("torque_front_right", want.fr, o_torque_front_right);
            end
        end
    end

    // present one word, wait for it to be taken, record its prediction
    task automatic send_word(input logic signed [tvlb_pkg::TRQ_W-1:0] trq,
                             input logic signed [tvlb_pkg::TRQ_W-1:0] ang, input logic sv);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_torque_request <= trq;
        i_steering_angle <= ang;
        i_sensor_valid   <= sv;
        do @(posedge i_clk); while (o_stall);
        pending_splits.push_back(predict_split(trq, ang, sv));
    endtask

    // hold the input off until every predicted word has come out
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_splits.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tvlb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tvlb_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // write all five registers, block must be idle
    task automatic program_regs(input logic [15:0] drv, input logic [15:0] rgn,
                                input logic [15:0] ab, input logic [15:0] ae,
                                input logic [15:0] le);
        write_reg(tvlb_pkg::CFG_DRV_REAR, drv);
        write_reg(tvlb_pkg::CFG_RGN_REAR, rgn);
        write_reg(tvlb_pkg::CFG_ANG_BEGIN, ab);
        write_reg(tvlb_pkg::CFG_ANG_END, ae);
        write_reg(tvlb_pkg::CFG_LEFT_END, le);
        i_cfg_we      <= 1'b0;
        cfg_drv_rear  = drv;
        cfg_rgn_rear  = rgn;
        cfg_ang_begin = ab[tvlb_pkg::ANG_W-1:0];
        cfg_ang_end   = ae[tvlb_pkg::ANG_W-1:0];
        cfg_left_end  = le;
    endtask

    // extremes of the fields under the reset registers
    task automatic test_reset_defaults();
        send_word(16'sd32767, 16'sd0, 1'b1);
        send_word(16'sd32767, 16'sd9000, 1'b1);
        send_word(16'sd32767, 16'sd4500, 1'b0);
        send_word(16'sd32767, -16'sd4500, 1'b1);
        send_word(16'sd32767, -16'sd18000, 1'b1);
        send_word(-16'sd32768, 16'sd6000, 1'b1);
        send_word(-16'sd1, -16'sd32768, 1'b0);
        send_word(16'sd0, 16'sd1000, 1'b1);
        send_word(16'sd1, 16'sd32767, 1'b1);
        send_word(16'sd12345, -16'sd32768, 1'b1);
    endtask

    // bias registers at zero, one and above one
    task automatic test_bias_extremes();
        drain();
        program_regs(16'hFFFF, 16'd0, 16'd0, 16'd18000, 16'd40000);
        send_word(16'sd32767, 16'sd18000, 1'b1);
        send_word(-16'sd32768, 16'sd18000, 1'b1);
        send_word(16'sd20000, -16'sd9000, 1'b1);
        drain();
        program_regs(16'd0, tvlb_pkg::ONE_Q15, 16'd100, 16'd200, 16'd0);
        send_word(16'sd32767, 16'sd150, 1'b1);
        send_word(-16'sd20000, -16'sd150, 1'b0);
    endtask

    // mirrored axis: begin angle above end angle
    task automatic test_begin_above_end();
        drain();
        program_regs(16'd20000, 16'd12000, 16'd12000, 16'd3000, 16'd30000);
        send_word(16'sd30000, 16'sd2000, 1'b1);
        send_word(16'sd30000, 16'sd3000, 1'b1);
        send_word(16'sd30000, 16'sd7000, 1'b1);
        send_word(16'sd30000, 16'sd12000, 1'b1);
        send_word(16'sd30000, -16'sd7000, 1'b1);
    endtask

    // begin equal to end: a step with no division
    task automatic test_begin_equal_end();
        drain();
        program_regs(16'd16384, 16'd16384, 16'd5000, 16'd5000, 16'd0);
        send_word(16'sd25000, 16'sd5000, 1'b1);
        send_word(16'sd25000, 16'sd5001, 1'b1);
        send_word(16'sd25000, -16'sd5001, 1'b1);
        send_word(16'sd25000, 16'sd0, 1'b0);
    endtask

    function automatic logic [15:0] pick_bias();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return tvlb_pkg::ONE_Q15;
            2: return 16'hFFFF;
            3: return 16'($urandom_range(65535));
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'd18000;
            2: return 16'h7FFF;
            3: return 16'($urandom_range(32767));
            default: return 16'($urandom_range(18000));
        endcase
    endfunction

    // random words in chunks, each chunk under a fresh random configuration
    task automatic test_random_words(input int n_words);
        int sent, chunk, t, a, off;
        logic [15:0] ab;
        sent = 0;
        while (sent < n_words) begin
            drain();
            ab = pick_angle();
            program_regs(pick_bias(), pick_bias(), ab,
                         ($urandom_range(9) == 0) ? ab : pick_angle(), pick_bias());
            chunk = $urandom_range(40, 100);
            if (chunk > n_words - sent)
                chunk = n_words - sent;
            repeat (chunk) begin
                case ($urandom_range(9))
                    0: t = 32767;
                    1: t = -32768;
                    2: t = int'($urandom_range(16)) - 8;
                    default: t = $urandom;
                endcase
                off = int'($urandom_range(4)) - 2;
                case ($urandom_range(9))
                    0: a = $urandom;
                    1: a = int'(cfg_ang_begin) + off;
                    2: a = int'(cfg_ang_end) + off;
                    3: a = -32768;
                    default: a = int'($urandom_range(36000)) - 18000;
                endcase
                // mirror the angle onto the opposite side at random, -32768 excepted
                if (($urandom_range(1) == 1) && (a > -32768) && (a < 32768))
                    a = -a;
                send_word(t[15:0], a[15:0], 1'($urandom_range(1)));
            end
            sent += chunk;
        end
    endtask

    initial begin
        snd_idle_pct  = 26;
        rcv_stall_pct = 70;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_bias_extremes();
        test_begin_above_end();
        test_begin_equal_end();
        test_random_words(300);

        snd_idle_pct  = 70;
        rcv_stall_pct = 26;
        test_random_words(300);

        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        test_random_words(250);

        drain();
        if (n_mismatch == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/tvlb_pkg.sv
sv/tvlb_cfg.sv
sv/tvlb_front.sv
sv/tvlb_div.sv
sv/tvlb_mix.sv
sv/torque_vectoring_linear_bias_top.sv
sv/tvlb_chk.sv
test/tb_torque_vectoring_linear_bias_top.sv
